// File: hdl/dht_pkg.sv
package dht_pkg;

  localparam int SLOTS = 1021;

  localparam int KEY_W      = 31;
  localparam int SLOT_OUT_W = 10;
  localparam int COLL_W     = 10;

  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Stored word: occupied flag on top, key below.
  localparam int WORD_W = KEY_W + 1;

  // Reciprocals for key mod SLOTS and key mod (SLOTS - 1). With a shift of
  // KEY_W + clog2(divisor) the estimated quotient is low by at most one.
  localparam int RCP_W  = 32;
  localparam int PROD_W = KEY_W + RCP_W;

  localparam int H_SH = KEY_W + $clog2(SLOTS);
  localparam int S_SH = KEY_W + $clog2(SLOTS - 1);
  localparam logic [RCP_W-1:0] H_RCP = RCP_W'((64'd1 << H_SH) / 64'(SLOTS));
  localparam logic [RCP_W-1:0] S_RCP = RCP_W'((64'd1 << S_SH) / 64'(SLOTS - 1));

  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] home;
    logic [ADDR_W-1:0] step;
  } hash_req_t;

endpackage

// File: hdl/dht_in_if.sv
interface dht_in_if import dht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

// File: hdl/dht_out_if.sv
interface dht_out_if import dht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  stored;
  logic [COLL_W-1:0]     collisions;

  modport source (output valid, output slot, output stored, output collisions, input ready);
  modport sink (input valid, input slot, input stored, input collisions, output ready);
endinterface

// File: hdl/double_hash_table_insert.sv
// Double-hashing insert into an open-addressed table of SLOTS entries
// (1021, prime). Each input beat carries a key; home is key mod SLOTS and
// the step is 1 + key mod (SLOTS - 1). One output beat per key gives the
// slot taken and the number of occupied slots met, or stored = 0 with
// collisions = SLOTS when the table is full. After reset the table is
// cleared one slot per cycle, so no key is taken until that pass is done.
// The hash front end does two reciprocal multiplies, a multiply-back and
// subtract, and a correction per key, and takes no new key until it has
// pushed the last into a 2-entry queue that feeds the prober. The prober
// reads the home slot and steps on its single-port table RAM until a slot
// is free or the table is full, one key at a time.
module double_hash_table_insert import dht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dht_in_if.sink    in_ch,
  dht_out_if.source out_ch
);

  logic      clearing;
  logic      q_push, q_full, q_pop, q_empty;
  hash_req_t q_wdata, q_rdata;

  dht_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .clearing_i  (clearing),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_key      (in_ch.key),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .full_i      (q_full)
  );

  dht_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  dht_probe u_probe (
    .clk            (clk),
    .rst_n          (rst_n),
    .clearing_o     (clearing),
    .empty_i        (q_empty),
    .req_i          (q_rdata),
    .pop_o          (q_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_slot       (out_ch.slot),
    .out_stored     (out_ch.stored),
    .out_collisions (out_ch.collisions)
  );

endmodule

// File: hdl/dht_hash.sv
module dht_hash import dht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clearing_i,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] in_key,
  output logic             push_o,
  output hash_req_t        push_data_o,
  input  logic             full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SUB  = 2'd2;
  localparam logic [1:0] F_FIX  = 2'd3;

  localparam logic [KEY_W-1:0] SLOTS_K    = KEY_W'(SLOTS);
  localparam logic [KEY_W-1:0] SLOTS_M1_K = KEY_W'(SLOTS - 1);

  logic [1:0]       st_r, st_nxt;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] hq_r, sq_r;
  logic [KEY_W-1:0] hr_r, sr_r;

  logic [PROD_W-1:0] h_prod, s_prod;
  logic [KEY_W-1:0]  h_back, s_back;
  logic [KEY_W-1:0]  h_rem, s_rem;

  assign h_prod = {{RCP_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, H_RCP};
  assign s_prod = {{RCP_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, S_RCP};
  assign h_back = hq_r * SLOTS_K;
  assign s_back = sq_r * SLOTS_M1_K;

  // Quotient estimate may be one short: fold the remainder once.
  assign h_rem = (hr_r >= SLOTS_K) ? hr_r - SLOTS_K : hr_r;
  assign s_rem = (sr_r >= SLOTS_M1_K) ? sr_r - SLOTS_M1_K : sr_r;

  assign in_ready = (st_r == F_IDLE) && !clearing_i;
  assign push_o   = (st_r == F_FIX);

  assign push_data_o.key  = key_r;
  assign push_data_o.home = ADDR_W'(h_rem);
  assign push_data_o.step = ADDR_W'(s_rem) + ADDR_W'(1);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: if (in_valid && in_ready) st_nxt = F_MUL;
      F_MUL:  st_nxt = F_SUB;
      F_SUB:  st_nxt = F_FIX;
      F_FIX:  if (!full_i) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) key_r <= in_key;
    if (st_r == F_MUL) begin
      hq_r <= KEY_W'(h_prod >> H_SH);
      sq_r <= KEY_W'(s_prod >> S_SH);
    end
    if (st_r == F_SUB) begin
      hr_r <= key_r - h_back;
      sr_r <= key_r - s_back;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_FIX) |-> (hr_r < (SLOTS_K << 1)) && (sr_r < (SLOTS_M1_K << 1)))
    else $error("hash remainder needs more than one correction");
`endif

endmodule

// File: hdl/dht_queue.sv
module dht_queue import dht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_i,
  input  hash_req_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output hash_req_t pop_data_o,
  output logic      empty_o
);

  hash_req_t        ent_r [QDEPTH];
  logic [QP_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full_o     = (cnt_r == QC_W'(QDEPTH));
  assign empty_o    = (cnt_r == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QP_W'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + QC_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_data_i;
  end

`ifndef NO_ASSERTIONS
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == '0) || (cnt_r == QC_W'(QDEPTH))) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// File: hdl/dht_probe.sv
module dht_probe import dht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  output logic                  clearing_o,
  input  logic                  empty_i,
  input  hash_req_t             req_i,
  output logic                  pop_o,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic                  out_stored,
  output logic [COLL_W-1:0]     out_collisions
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  localparam logic [ADDR_W:0] SLOTS_A = (ADDR_W + 1)'(SLOTS);

  logic [1:0]        st_r, st_nxt;
  logic [ADDR_W-1:0] clr_r;
  logic [ADDR_W-1:0] pos_r, step_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  probes_r;

  logic [WORD_W-1:0] mem [SLOTS];
  logic [WORD_W-1:0] rd_data_r;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [ADDR_W:0]   pos_sum;
  logic [ADDR_W-1:0] pos_adv;
  logic [CNT_W-1:0]  probes_inc;
  logic              slot_free, table_full;

  logic                  out_valid_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic                  out_stored_r;
  logic [COLL_W-1:0]     out_coll_r;

  assign clearing_o = (st_r == ST_INIT);
  assign pop_o      = (st_r == ST_IDLE) && !empty_i && (!out_valid_r || out_ready);

  assign pos_sum    = {1'b0, pos_r} + {1'b0, step_r};
  assign pos_adv    = ADDR_W'((pos_sum >= SLOTS_A) ? pos_sum - SLOTS_A : pos_sum);
  assign probes_inc = probes_r + CNT_W'(1);
  assign slot_free  = !rd_data_r[WORD_W-1];
  assign table_full = (probes_inc == CNT_W'(SLOTS));

  always_comb begin
    st_nxt  = st_r;
    rd_en   = 1'b0;
    rd_addr = pos_adv;
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = {1'b1, key_r};
    unique case (st_r)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        if (clr_r == ADDR_W'(SLOTS - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop_o) begin
          rd_en   = 1'b1;
          rd_addr = req_i.home;
          st_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (slot_free) begin
          wr_en  = 1'b1;
          st_nxt = ST_IDLE;
        end else if (table_full) begin
          st_nxt = ST_IDLE;
        end else begin
          // Issue the next probe right away: one slot per cycle.
          rd_en = 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_INIT) clr_r <= clr_r + ADDR_W'(1);
      if ((st_r == ST_CHECK) && (slot_free || table_full)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      pos_r    <= req_i.home;
      step_r   <= req_i.step;
      key_r    <= req_i.key;
      probes_r <= '0;
    end else if ((st_r == ST_CHECK) && !slot_free && !table_full) begin
      pos_r    <= pos_adv;
      probes_r <= probes_inc;
    end
    if (st_r == ST_CHECK) begin
      if (slot_free) begin
        out_slot_r   <= SLOT_OUT_W'(pos_r);
        out_stored_r <= 1'b1;
        out_coll_r   <= COLL_W'(probes_r);
      end else if (table_full) begin
        out_slot_r   <= '0;
        out_stored_r <= 1'b0;
        out_coll_r   <= COLL_W'(probes_inc);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_stored     = out_stored_r;
  assign out_collisions = out_coll_r;

`ifndef NO_ASSERTIONS
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHECK) |-> !out_valid_r)
    else $error("probe finished while a result was still held");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHECK) |-> (probes_r < CNT_W'(SLOTS)) && (pos_r < ADDR_W'(SLOTS)))
    else $error("probe count or slot out of range");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_INIT) |-> !pop_o && !out_valid_r)
    else $error("work started during clearing pass");
`endif

endmodule
